/* rtl/kmgr_pkg.sv */
// ----------------------------------------------------------------------------
// kmgr_pkg
// Shared constants and types for the key matrix ghost resolver.
// ----------------------------------------------------------------------------
package kmgr_pkg;

  localparam int unsigned ROWS       = 8;
  localparam int unsigned COLS       = 8;
  localparam int unsigned MAX_ROUNDS = 17;
  localparam int unsigned RND_W      = $clog2(MAX_ROUNDS);

  localparam logic [COLS-1:0] ON_BIT = 8'h80;
  localparam int unsigned     ON_IDX = 7;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  typedef struct packed {
    logic [COLS-1:0] col_low;
    logic            row_low;
  } lane_res_t;

  typedef struct packed {
    logic [COLS-1:0] next_a;
    logic [ROWS-1:0] next_b;
    logic            changed;
  } merge_res_t;

endpackage

/* rtl/kmgr_lane.sv */
// ----------------------------------------------------------------------------
// kmgr_lane
// One row of the matrix: spreads low levels across that row's closed switches.
// ----------------------------------------------------------------------------
module kmgr_lane (
  input  logic [kmgr_pkg::COLS-1:0] closed,
  input  logic                      row_low,
  input  logic [kmgr_pkg::COLS-1:0] low_a,
  output kmgr_pkg::lane_res_t       res
);
  import kmgr_pkg::*;

  always_comb begin
    res.col_low = row_low ? closed : '0;
    res.row_low = |(closed & low_a);
  end

endmodule

/* rtl/kmgr_merge.sv */
// ----------------------------------------------------------------------------
// kmgr_merge
// Combines the row lanes into the next line levels and flags any change.
// ----------------------------------------------------------------------------
module kmgr_merge (
  input  logic [kmgr_pkg::COLS-1:0] low_a,
  input  logic [kmgr_pkg::ROWS-1:0] low_b,
  input  kmgr_pkg::lane_res_t       lanes [kmgr_pkg::ROWS],
  output kmgr_pkg::merge_res_t      res
);
  import kmgr_pkg::*;

  logic [COLS-1:0] a_acc;
  logic [ROWS-1:0] b_acc;

  always_comb begin
    a_acc = low_a;
    b_acc = low_b;
    for (int r = 0; r < ROWS; r++) begin
      a_acc    = a_acc | lanes[r].col_low;
      b_acc[r] = b_acc[r] | lanes[r].row_low;
    end
    res.next_a  = a_acc;
    res.next_b  = b_acc;
    res.changed = (a_acc != low_a) || (b_acc != low_b);
  end

endmodule

/* rtl/key_matrix_ghost_resolver.sv */
// ----------------------------------------------------------------------------
// key_matrix_ghost_resolver
// Resolves the Port A read value of an undioded key matrix, ghost keys included.
// ----------------------------------------------------------------------------
// Timing: from the accepting edge, propagation rounds run with all rows in
//   parallel until stable or until MAX_ROUNDS rounds have run.
// Flow: one transaction at a time; start is taken again in the cycle
//   the result is shown.
// Reset: rst_n clears the sequencer and the strobe; no other state.
// The receiver cannot stall: each result is strobed for exactly one cycle.
module key_matrix_ghost_resolver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_key_open_bits,
  input  logic [7:0]  in_pa_direction,
  input  logic [7:0]  in_pa_output_latch,
  input  logic [7:0]  in_pb_direction,
  input  logic [7:0]  in_pb_output_latch,
  input  logic        in_on_key_down,
  output logic        out_valid,
  output logic [7:0]  out_pa_pin_level,
  output logic [7:0]  out_pa_read_value
);
  import kmgr_pkg::*;

  logic                  state_r, state_nxt;
  logic [RND_W-1:0]      rnd_r, rnd_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [63:0]           open_r;
  logic [COLS-1:0]       dira_r, lata_r;
  logic                  on_r;
  logic [COLS-1:0]       low_a_r, low_a_nxt;
  logic [ROWS-1:0]       low_b_r, low_b_nxt;
  logic [COLS-1:0]       pin_r, pin_nxt;
  logic [COLS-1:0]       rd_r, rd_nxt;
  logic                  accept;
  logic                  done;
  logic [COLS-1:0]       fin_a;
  lane_res_t             lanes [ROWS];
  merge_res_t            mres;

  assign busy   = (state_r == ST_RUN);
  assign accept = start && !busy;

  for (genvar r = 0; r < ROWS; r++) begin : g_lane
    kmgr_lane u_lane (
      .closed  (~open_r[COLS*r +: COLS]),
      .row_low (low_b_r[r]),
      .low_a   (low_a_r),
      .res     (lanes[r])
    );
  end

  kmgr_merge u_merge (
    .low_a (low_a_r),
    .low_b (low_b_r),
    .lanes (lanes),
    .res   (mres)
  );

  assign done  = !mres.changed || (rnd_r == RND_W'(MAX_ROUNDS - 1));
  assign fin_a = on_r ? (mres.next_a | ON_BIT) : mres.next_a;

  always_comb begin
    state_nxt     = state_r;
    rnd_nxt       = rnd_r;
    out_valid_nxt = 1'b0;
    low_a_nxt     = low_a_r;
    low_b_nxt     = low_b_r;
    pin_nxt       = pin_r;
    rd_nxt        = rd_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_RUN;
          rnd_nxt   = '0;
          low_a_nxt = ~(in_pa_direction | in_pa_output_latch);
          low_b_nxt = ROWS'(~(in_pb_direction | in_pb_output_latch));
        end
      end
      ST_RUN: begin
        low_a_nxt = mres.next_a;
        low_b_nxt = mres.next_b;
        rnd_nxt   = rnd_r + RND_W'(1);
        if (done) begin
          state_nxt      = ST_IDLE;
          out_valid_nxt  = 1'b1;
          pin_nxt        = ~fin_a;
          rd_nxt         = (~fin_a & dira_r) | (lata_r & ~dira_r);
          rd_nxt[ON_IDX] = ~on_r;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rnd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rnd_r       <= rnd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      open_r <= in_key_open_bits;
      dira_r <= in_pa_direction;
      lata_r <= in_pa_output_latch;
      on_r   <= in_on_key_down;
    end
    low_a_r <= low_a_nxt;
    low_b_r <= low_b_nxt;
    pin_r   <= pin_nxt;
    rd_r    <= rd_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_pa_pin_level  = pin_r;
  assign out_pa_read_value = rd_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for two cycles");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_IDLE))
    else $error("result shown while resolver is running");

  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (rnd_r < RND_W'(MAX_ROUNDS)))
    else $error("propagation round count overran");

  a_low_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && $past(busy)) |-> ((low_a_r & $past(low_a_r)) == $past(low_a_r)))
    else $error("a low column level was lost during propagation");

  a_on_bit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (rd_r[ON_IDX] == !on_r) && (!on_r || !pin_r[ON_IDX]))
    else $error("ON key bit wrong in result");

endmodule
